// ===== rtl/sbsc_pkg.sv =====
// Shared types, constants and helper functions for the stereo band-split chorus.
// Holds the config struct, the lane step codes and the quarter-wave sine table.
// No dependencies.
package sbsc_pkg;

  localparam int DELAY_DEPTH     = 8192;
  localparam int SINE_TABLE_BITS = 10;

  localparam int ADDR_W       = $clog2(DELAY_DEPTH);
  localparam int IDX_W        = ADDR_W + 2;
  localparam int QUARTER_LEN  = 1 << (SINE_TABLE_BITS - 2);
  localparam int SINE_ENTRIES = QUARTER_LEN + 1;
  localparam int SINE_W       = 15;
  localparam int SINE_IDX_W   = SINE_TABLE_BITS - 1;

  localparam int SMP_W      = 24;
  localparam int LINE_W     = 25;
  localparam int LOW_W      = 40;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [14:0] EMPH_Q14 = 15'sd7373;
  localparam logic signed [14:0] TRIM_Q14 = 15'sd12780;
  localparam logic [31:0] THIRD_TURN     = 32'h5555_5555;
  localparam logic [16:0] MIX_FULL       = 17'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE,
    REG_PHASE_STEP,
    REG_DEPTH_DELAY,
    REG_BASE_DELAY,
    REG_LOWPASS_COEF,
    REG_HIGH_DRY_GAIN,
    REG_HIGH_WET_GAIN,
    REG_FINAL_MIX
  } reg_idx_t;

  typedef struct packed {
    logic        enable;
    logic [23:0] phase_step;
    logic [15:0] depth_delay;
    logic [15:0] base_delay;
    logic [15:0] lowpass_coef;
    logic [14:0] high_dry_gain;
    logic [14:0] high_wet_gain;
    logic [15:0] final_mix;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable:        1'b0,
    phase_step:    24'd67109,
    depth_delay:   16'd5120,
    base_delay:    16'd5888,
    lowpass_coef:  16'd1114,
    high_dry_gain: 15'd4915,
    high_wet_gain: 15'd20070,
    final_mix:     16'd19661
  };

  // One step of the per-channel schedule, one multiply at most per step.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LP_MUL,
    OP_LP_ADD,
    OP_EMPH_MUL,
    OP_EMPH_ADD,
    OP_DLY_ADD,
    OP_RD,
    OP_TAP,
    OP_WSUM,
    OP_TRIM,
    OP_IN_MIX,
    OP_WET_MIX,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              clear;
    logic [ADDR_W-1:0] wr_addr;
  } ctrl_t;

  function automatic op_t next_op(input op_t cur);
    op_t nxt;
    unique case (cur)
      OP_LP_MUL:   nxt = OP_LP_ADD;
      OP_LP_ADD:   nxt = OP_EMPH_MUL;
      OP_EMPH_MUL: nxt = OP_EMPH_ADD;
      OP_EMPH_ADD: nxt = OP_DLY_ADD;
      OP_DLY_ADD:  nxt = OP_RD;
      OP_RD:       nxt = OP_TAP;
      OP_TAP:      nxt = OP_WSUM;
      OP_WSUM:     nxt = OP_TRIM;
      OP_TRIM:     nxt = OP_IN_MIX;
      OP_IN_MIX:   nxt = OP_WET_MIX;
      OP_WET_MIX:  nxt = OP_OUT;
      default:     nxt = OP_IDLE;
    endcase
    return nxt;
  endfunction

  // Quarter-wave sine, Q1.15, built at elaboration by a Taylor series.
  function automatic logic [SINE_ENTRIES*SINE_W-1:0] build_sine_rom();
    logic [SINE_ENTRIES*SINE_W-1:0] rom;
    longint unsigned x;
    longint unsigned term;
    longint          s;
    rom = '0;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) / QUARTER_LEN;
      term = x;
      s    = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        unique case (n)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          5:       term = term / 110;
          default: term = term / 156;
        endcase
        if ((n & 1) != 0) s = s - longint'(term);
        else              s = s + longint'(term);
      end
      s = (s + 16384) >>> 15;
      if (s < 0)          s = 0;
      else if (s > 32767) s = 32767;
      rom[k*SINE_W +: SINE_W] = s[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam logic [SINE_ENTRIES*SINE_W-1:0] SINE_ROM = build_sine_rom();

  function automatic logic signed [15:0] sine_at(input logic [31:0] phase);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS-3:0] k;
    logic [SINE_IDX_W-1:0]      ent;
    logic [SINE_W-1:0]          mag;
    idx = phase[31 -: SINE_TABLE_BITS];
    k   = idx[SINE_TABLE_BITS-3:0];
    ent = idx[SINE_TABLE_BITS-2] ? (SINE_IDX_W'(QUARTER_LEN) - {1'b0, k}) : {1'b0, k};
    mag = SINE_ROM[ent*SINE_W +: SINE_W];
    return idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// ===== rtl/sbsc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sbsc_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sbsc_lane.sv =====
// One channel lane: lowpass split, emphasis, modulated delay tap, wet/dry mix.
// Depends on sbsc_pkg and sbsc_ram (the channel's delay line).
module sbsc_lane
  import sbsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_t                   ctrl,
  input  cfg_t                    cfg,
  input  logic signed [SMP_W-1:0] sample,
  input  logic [31:0]             phase,
  output logic signed [SMP_W-1:0] result
);

  localparam logic signed [IDX_W-1:0] DEPTH_S = IDX_W'(DELAY_DEPTH);

  // filter state
  logic signed [LOW_W-1:0]  low;
  logic signed [LINE_W-1:0] prev;

  // step registers
  logic signed [57:0]       lp_prod;
  logic signed [SMP_W-1:0]  low_s;
  logic signed [LINE_W-1:0] high;
  logic signed [39:0]       emph_prod;
  logic signed [LINE_W-1:0] bright;
  logic signed [32:0]       dly_prod;
  logic signed [9:0]        dly_int;
  logic signed [39:0]       dry_prod;
  logic signed [39:0]       wet_prod;
  logic signed [41:0]       wsum;
  logic signed [56:0]       trim_prod;
  logic signed [28:0]       wet;
  logic signed [40:0]       in_prod;
  logic signed [45:0]       mix_prod;

  // combinational
  logic signed [40:0]       lp_diff;
  logic signed [16:0]       coef_s;
  logic signed [57:0]       lp_mul;
  logic signed [LOW_W-1:0]  low_sum;
  logic signed [LINE_W-1:0] high_next;
  logic signed [25:0]       hp_diff;
  logic signed [39:0]       emph_mul;
  logic signed [39:0]       emph_rnd;
  logic signed [25:0]       emph_q;
  logic signed [26:0]       bright_raw;
  logic signed [LINE_W-1:0] bright_sat;
  logic signed [15:0]       sine_v;
  logic signed [16:0]       depth_s;
  logic signed [32:0]       dly_mul;
  logic signed [18:0]       dly_q8;
  logic signed [18:0]       dly_adj;
  logic signed [IDX_W-1:0]  rd_diff;
  logic signed [IDX_W-1:0]  rd_w1;
  logic signed [IDX_W-1:0]  rd_w2;
  logic signed [IDX_W-1:0]  rd_w3;
  logic [ADDR_W-1:0]        rd_addr;
  logic [LINE_W-1:0]        ram_rdata;
  logic                     ram_we;
  logic [LINE_W-1:0]        ram_wdata;
  logic signed [LINE_W-1:0] tap;
  logic signed [39:0]       dry_mul;
  logic signed [39:0]       wet_mul;
  logic signed [41:0]       wsum_next;
  logic signed [56:0]       trim_mul;
  logic signed [56:0]       trim_rnd;
  logic signed [28:0]       wet_next;
  logic [16:0]              mix_eff;
  logic signed [16:0]       mix_s;
  logic signed [16:0]       dry_share_s;
  logic signed [40:0]       in_mul;
  logic signed [45:0]       mix_mul;
  logic signed [46:0]       out_sum;
  logic signed [31:0]       out_q;
  logic signed [SMP_W-1:0]  out_sat;

  always_comb begin
    // lowpass: low += floor(coef * (in*2^16 - low) / 2^16)
    lp_diff   = 41'($signed({sample, 16'h0000})) - 41'(low);
    coef_s    = $signed({1'b0, cfg.lowpass_coef});
    lp_mul    = coef_s * lp_diff;
    low_sum   = low + LOW_W'($signed(lp_prod[57:16]));
    high_next = LINE_W'(sample) - LINE_W'($signed(low_sum[39:16]));

    // emphasis, rounded half up, then clamped to the line width
    hp_diff    = 26'(high) - 26'(prev);
    emph_mul   = EMPH_Q14 * hp_diff;
    emph_rnd   = emph_prod + 40'sd8192;
    emph_q     = $signed(emph_rnd[39:14]);
    bright_raw = 27'(high) + 27'(emph_q);
    if (bright_raw > 27'sd16777215)       bright_sat = 25'sh0FF_FFFF;
    else if (bright_raw < -27'sd16777216) bright_sat = 25'sh100_0000;
    else                                  bright_sat = bright_raw[LINE_W-1:0];

    // modulated delay, Q8.8; integer part truncated toward zero
    sine_v  = sine_at(phase);
    depth_s = $signed({1'b0, cfg.depth_delay});
    dly_mul = depth_s * sine_v;
    dly_q8  = 19'($signed({1'b0, cfg.base_delay})) + 19'($signed(dly_prod[32:15]));
    dly_adj = dly_q8[18] ? (dly_q8 + 19'sd255) : dly_q8;

    // read index wraps into the line; the delay swing is under two depths
    rd_diff = $signed({2'b00, ctrl.wr_addr}) - IDX_W'(dly_int);
    rd_w1   = (rd_diff < 0) ? (rd_diff + DEPTH_S) : rd_diff;
    rd_w2   = (rd_w1 < 0) ? (rd_w1 + DEPTH_S) : rd_w1;
    rd_w3   = (rd_w2 >= DEPTH_S) ? (rd_w2 - DEPTH_S) : rd_w2;
    rd_addr = rd_w3[ADDR_W-1:0];

    tap     = $signed(ram_rdata);
    dry_mul = bright * $signed({1'b0, cfg.high_dry_gain});
    wet_mul = tap * $signed({1'b0, cfg.high_wet_gain});

    wsum_next = 42'($signed({low_s, 14'h0000})) + 42'(dry_prod) + 42'(wet_prod);
    trim_mul  = wsum * TRIM_Q14;
    trim_rnd  = trim_prod + 57'sd134217728;
    wet_next  = $signed(trim_rnd[56:28]);

    // final mix, wet share clamped at full
    mix_eff     = (cfg.final_mix > 16'd32768) ? MIX_FULL : {1'b0, cfg.final_mix};
    mix_s       = $signed(mix_eff);
    dry_share_s = $signed(MIX_FULL - mix_eff);
    in_mul      = sample * dry_share_s;
    mix_mul     = wet * mix_s;
    out_sum     = 47'(in_prod) + 47'(mix_prod) + 47'sd16384;
    out_q       = $signed(out_sum[46:15]);
    if (out_q > 32'sd8388607)       out_sat = 24'sh7F_FFFF;
    else if (out_q < -32'sd8388608) out_sat = 24'sh80_0000;
    else                            out_sat = out_q[SMP_W-1:0];

    ram_we    = ctrl.clear || (ctrl.op == OP_TAP);
    ram_wdata = ctrl.clear ? '0 : bright;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= '0;
      prev <= '0;
    end else begin
      if (ctrl.op == OP_LP_ADD) begin
        low <= low_sum;
      end
      if (ctrl.op == OP_EMPH_MUL) begin
        prev <= high;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LP_MUL: lp_prod <= lp_mul;
      OP_LP_ADD: begin
        low_s <= $signed(low_sum[39:16]);
        high  <= high_next;
      end
      OP_EMPH_MUL: emph_prod <= emph_mul;
      OP_EMPH_ADD: begin
        bright   <= bright_sat;
        dly_prod <= dly_mul;
      end
      OP_DLY_ADD: begin
        dly_int  <= $signed(dly_adj[17:8]);
        dry_prod <= dry_mul;
      end
      OP_TAP:     wet_prod <= wet_mul;
      OP_WSUM:    wsum <= wsum_next;
      OP_TRIM:    trim_prod <= trim_mul;
      OP_IN_MIX: begin
        wet     <= wet_next;
        in_prod <= in_mul;
      end
      OP_WET_MIX: mix_prod <= mix_mul;
      OP_OUT:     result <= out_sat;
      default: ;
    endcase
  end

  // read issued in OP_RD, data used in OP_TAP while the new sample is written
  sbsc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ctrl.wr_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/stereo_band_split_chorus_core.sv =====
// Stereo band-split chorus, top level: config registers, sequencer, two lanes.
// Depends on sbsc_pkg and sbsc_lane (which holds sbsc_ram).
// With the effect on, a word runs the 12-step lane schedule, then waits in ST_DONE; in bypass
// it goes straight to ST_DONE. in_ready stays low until the word moves to the output register.
// Reset: sync, active high; then a sweep over all DELAY_DEPTH addresses zeroes both delay
// lines with in_ready low; config writes are taken during the sweep.
module stereo_band_split_chorus_core
  import sbsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] left_in,
  input  logic signed [SMP_W-1:0] right_in,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] left_out,
  output logic signed [SMP_W-1:0] right_out
);

  // ST_CLEAR: delay-line sweep after reset, write_pos doubles as sweep address
  // ST_RUN:   lanes step through the schedule held in op
  // ST_DONE:  result waits for the output register to free up
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t               state;
  op_t                  op;
  cfg_t                 cfg;
  logic [ADDR_W-1:0]    write_pos;
  logic [ADDR_W-1:0]    wp_next;
  logic [31:0]          lfo_phase;
  logic [31:0]          phase_r;
  logic                 bypass;
  logic signed [SMP_W-1:0] left_smp;
  logic signed [SMP_W-1:0] right_smp;
  logic signed [SMP_W-1:0] left_res;
  logic signed [SMP_W-1:0] right_res;
  logic                 in_fire;
  logic                 load;
  ctrl_t                ctrl;

  always_comb begin
    in_ready = (state == ST_IDLE);
    in_fire  = in_valid && in_ready;
    load     = (state == ST_DONE) && (!out_valid || out_ready);
    wp_next  = (write_pos == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : (write_pos + 1'b1);
    // right LFO runs a third of a turn ahead
    phase_r  = lfo_phase + THIRD_TURN;

    ctrl.op      = (state == ST_RUN) ? op : OP_IDLE;
    ctrl.clear   = (state == ST_CLEAR);
    ctrl.wr_addr = write_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      op        <= OP_IDLE;
      cfg       <= CFG_RESET;
      write_pos <= '0;
      lfo_phase <= '0;
      bypass    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ENABLE:        cfg.enable        <= cfg_data[0];
          REG_PHASE_STEP:    cfg.phase_step    <= cfg_data[23:0];
          REG_DEPTH_DELAY:   cfg.depth_delay   <= cfg_data[15:0];
          REG_BASE_DELAY:    cfg.base_delay    <= cfg_data[15:0];
          REG_LOWPASS_COEF:  cfg.lowpass_coef  <= cfg_data[15:0];
          REG_HIGH_DRY_GAIN: cfg.high_dry_gain <= cfg_data[14:0];
          REG_HIGH_WET_GAIN: cfg.high_wet_gain <= cfg_data[14:0];
          REG_FINAL_MIX:     cfg.final_mix     <= cfg_data[15:0];
        endcase
      end

      if (in_fire) begin
        left_smp  <= left_in;
        right_smp <= right_in;
      end

      if (load) begin
        out_valid <= 1'b1;
        left_out  <= bypass ? left_smp : left_res;
        right_out <= bypass ? right_smp : right_res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          write_pos <= wp_next;
          if (write_pos == ADDR_W'(DELAY_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            bypass <= !cfg.enable;
            if (cfg.enable) begin
              state <= ST_RUN;
              op    <= OP_LP_MUL;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RUN: begin
          if (op == OP_OUT) begin
            state <= ST_DONE;
          end else begin
            op <= next_op(op);
          end
        end
        ST_DONE: begin
          if (load) begin
            // pointer moves in bypass too; the LFO only when processing
            write_pos <= wp_next;
            if (!bypass) begin
              lfo_phase <= lfo_phase + {8'h00, cfg.phase_step};
            end
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  sbsc_lane u_lane_left (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .sample (left_smp),
    .phase  (lfo_phase),
    .result (left_res)
  );

  sbsc_lane u_lane_right (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .sample (right_smp),
    .phase  (phase_r),
    .result (right_res)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input taken while a word is in flight");

  a_wp_moves_on_load: assert property (@(posedge clk) disable iff (rst)
    load |=> (write_pos != $past(write_pos)))
    else $error("write pointer did not advance for a delivered word");

  a_lfo_hold_bypass: assert property (@(posedge clk) disable iff (rst)
    (load && bypass) |=> $stable(lfo_phase))
    else $error("LFO phase moved in bypass");

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && op == OP_OUT) |=> (state == ST_DONE))
    else $error("schedule did not end in the done state");
`endif

endmodule

// ===== sim/stereo_band_split_chorus_core_tb.sv =====
// Self-checking bench for stereo_band_split_chorus_core: a directed table, then random words
// under changing settings and idle patterns, checked by a bit-true predictor or typed results.
// Depends on sbsc_pkg and the core RTL.
module stereo_band_split_chorus_core_tb
  import sbsc_pkg::*;
();

  typedef logic signed [SMP_W-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  // One row of the directed table: which setting, the word, and (for rows whose answer
  // is obvious) the typed-in result.
  typedef struct packed {
    logic [2:0] setting;
    sample_t    left;
    sample_t    right;
    logic       typed;
    sample_t    exp_left;
    sample_t    exp_right;
  } dir_row_t;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_SLACK    = 40;   // well past the effect latency
  localparam int HOLD_CYCLES    = 300;  // long output stall, fills the block
  localparam int RAND_SEGS      = 12;
  localparam int SEG_WORDS      = 96;
  localparam int DIR_SETTINGS   = 5;
  localparam int DIR_ROWS_N     = 23;

  localparam sample_t SMP_MAX = 24'sh7FFFFF;
  localparam sample_t SMP_MIN = 24'sh800000;

  // Fixed-point constants of the chorus math.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint EMPH_GAIN  = 7373;   // 0.45 in Q1.14
  localparam longint TRIM_GAIN  = 12780;  // 0.78 in Q1.14
  localparam logic [31:0] RIGHT_LFO_OFFSET = 32'h5555_5555;  // +1/3 turn
  localparam int QTR = 1 << (SINE_TABLE_BITS - 2);

  // Settings 0/1 have obvious answers: bypass, and effect on with a fully dry mix.
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{3'd0, 24'sd0,       24'sd0,       1'b1, 24'sd0,   24'sd0},
    '{3'd0, SMP_MAX,      SMP_MIN,      1'b1, SMP_MAX,  SMP_MIN},
    '{3'd0, SMP_MIN,      SMP_MAX,      1'b1, SMP_MIN,  SMP_MAX},
    '{3'd0, -24'sd1,      24'sd1,       1'b1, -24'sd1,  24'sd1},
    '{3'd0, 24'sh555555,  24'shAAAAAA,  1'b1, 24'sh555555, 24'shAAAAAA},
    '{3'd1, SMP_MAX,      SMP_MIN,      1'b1, SMP_MAX,  SMP_MIN},
    '{3'd1, SMP_MIN,      SMP_MAX,      1'b1, SMP_MIN,  SMP_MAX},
    '{3'd1, 24'sd0,       24'sd0,       1'b1, 24'sd0,   24'sd0},
    '{3'd1, 24'sd1,       -24'sd1,      1'b1, 24'sd1,   -24'sd1},
    '{3'd2, SMP_MAX,      SMP_MAX,      1'b0, 24'sd0,   24'sd0},
    '{3'd2, SMP_MIN,      SMP_MIN,      1'b0, 24'sd0,   24'sd0},
    '{3'd2, SMP_MAX,      SMP_MIN,      1'b0, 24'sd0,   24'sd0},
    '{3'd2, SMP_MIN,      SMP_MAX,      1'b0, 24'sd0,   24'sd0},
    '{3'd2, 24'sd0,       24'sd0,       1'b0, 24'sd0,   24'sd0},
    '{3'd2, 24'sd12345,   -24'sd54321,  1'b0, 24'sd0,   24'sd0},
    '{3'd3, SMP_MAX,      SMP_MIN,      1'b0, 24'sd0,   24'sd0},
    '{3'd3, SMP_MIN,      SMP_MAX,      1'b0, 24'sd0,   24'sd0},
    '{3'd3, 24'sd0,       24'sd0,       1'b0, 24'sd0,   24'sd0},
    '{3'd3, -24'sd1,      -24'sd1,      1'b0, 24'sd0,   24'sd0},
    '{3'd3, SMP_MAX,      SMP_MAX,      1'b0, 24'sd0,   24'sd0},
    '{3'd4, SMP_MIN,      SMP_MAX,      1'b0, 24'sd0,   24'sd0},
    '{3'd4, SMP_MAX,      SMP_MIN,      1'b0, 24'sd0,   24'sd0},
    '{3'd4, 24'sd777,     -24'sd777,    1'b0, 24'sd0,   24'sd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic    in_valid  = 1'b0;
  logic    in_ready;
  sample_t left_in   = '0;
  sample_t right_in  = '0;

  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t left_out;
  sample_t right_out;

  stereo_band_split_chorus_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Predictor state: shadow of the registers plus the chorus state per channel
  // (index 0 left, 1 right).
  cfg_t        cfg_shadow;
  int          sine_quarter [0:QTR];
  int          dly_line [2][DELAY_DEPTH];
  longint      lp_state [2];
  longint      prev_high [2];
  int unsigned wr_pos;
  logic [31:0] lfo_phase;

  pair_t expected_pairs [$];

  // Stimulus knobs, owned by the driver.
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned hold_reqs      = 0;

  // Bookkeeping for the end-of-run summary.
  int fails           = 0;
  int words_in        = 0;
  int words_out       = 0;
  int settings_used   = 0;
  int in_wait_cycles  = 0;
  int out_wait_cycles = 0;

  cfg_t dir_cfgs [DIR_SETTINGS];

  // Quarter-wave sine, Q1.15: Taylor series to x^13 in Q30, rounded and clamped.
  function automatic void fill_sine_quarter();
    longint unsigned x, term;
    longint          acc;
    for (int k = 0; k <= QTR; k++) begin
      x    = HALF_PI_Q30 * k / QTR;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - longint'(term);
        else            acc = acc + longint'(term);
      end
      acc = (acc + 16384) >>> 15;
      if (acc < 0)          acc = 0;
      else if (acc > 32767) acc = 32767;
      sine_quarter[k] = int'(acc);
    end
  endfunction

  // Top bits of the phase pick the entry; quadrant folds and negates.
  function automatic longint lfo_sine(input logic [31:0] phase);
    int     ix, k;
    longint v;
    ix = int'(phase >> (32 - SINE_TABLE_BITS));
    k  = ix % QTR;
    v  = ((ix / QTR) % 2 == 1) ? sine_quarter[QTR - k] : sine_quarter[k];
    return (ix / QTR >= 2) ? -v : v;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One channel with the effect on: split, emphasis, modulated tap, mix, trim, saturate.
  function automatic longint chorus_channel(input int ch, input longint smp,
                                            input logic [31:0] phase);
    longint lp_k, depth, base, dry_g, wet_g, mix;
    longint low_s, high, bright, dly_q8, d, idx, tap, wet, res;
    lp_k  = cfg_shadow.lowpass_coef;
    depth = cfg_shadow.depth_delay;
    base  = cfg_shadow.base_delay;
    dry_g = cfg_shadow.high_dry_gain;
    wet_g = cfg_shadow.high_wet_gain;
    mix   = cfg_shadow.final_mix;
    if (mix > 32768) mix = 32768;

    lp_state[ch] = lp_state[ch] + ((lp_k * (smp * 65536 - lp_state[ch])) >>> 16);
    low_s  = lp_state[ch] >>> 16;
    high   = smp - low_s;
    bright = high + ((EMPH_GAIN * (high - prev_high[ch]) + 8192) >>> 14);
    bright = clamp(bright, -(64'sd1 <<< 24), (64'sd1 <<< 24) - 1);
    prev_high[ch] = high;

    // Delay in Q8.8, integer part toward zero; read wraps, read comes before write.
    dly_q8 = base + ((depth * lfo_sine(phase)) >>> 15);
    d      = dly_q8 / 256;
    idx    = (longint'(wr_pos) - d) % DELAY_DEPTH;
    if (idx < 0) idx = idx + DELAY_DEPTH;
    tap = dly_line[ch][idx];
    dly_line[ch][wr_pos] = int'(bright);

    wet = low_s * 16384 + bright * dry_g + tap * wet_g;
    wet = (wet * TRIM_GAIN + 64'sd134217728) >>> 28;
    res = (smp * (32768 - mix) + wet * mix + 16384) >>> 15;
    return clamp(res, -8388608, 8388607);
  endfunction

  // Expected output pair for one accepted input word; advances the predictor state.
  function automatic pair_t chorus_pair(input pair_t w);
    pair_t res;
    res = w;
    if (cfg_shadow.enable) begin
      res.left  = sample_t'(chorus_channel(0, longint'($signed(w.left)), lfo_phase));
      res.right = sample_t'(chorus_channel(1, longint'($signed(w.right)),
                                           lfo_phase + RIGHT_LFO_OFFSET));
      lfo_phase = lfo_phase + 32'(cfg_shadow.phase_step);
    end
    // Write pointer advances in bypass too.
    wr_pos = (wr_pos + 1) % DELAY_DEPTH;
    return res;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(7))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return sample_t'($urandom_range(8191)) - sample_t'(4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.left  = rand_sample();
    p.right = rand_sample();
    return p;
  endfunction

  // Bias toward the field's extremes.
  function automatic logic [23:0] rand_field(input int w);
    logic [23:0] ones;
    ones = (24'h1 << w) - 24'h1;
    case ($urandom_range(7))
      0:       return '0;
      1:       return ones;
      default: return 24'($urandom) & ones;
    endcase
  endfunction

  function automatic cfg_t random_cfg(input bit on);
    cfg_t c;
    c.enable        = on;
    c.phase_step    = 24'(rand_field(24));
    c.depth_delay   = 16'(rand_field(16));
    c.base_delay    = 16'(rand_field(16));
    c.lowpass_coef  = 16'(rand_field(16));
    c.high_dry_gain = 15'(rand_field(15));
    c.high_wet_gain = 15'(rand_field(15));
    // Mostly in range, sometimes above full wet to hit the mix clamp.
    c.final_mix = ($urandom_range(7) == 0) ? 16'($urandom_range(65535, 32769))
                                           : 16'($urandom_range(32768));
    return c;
  endfunction

  // Garbage above the field width must be dropped by the register.
  function automatic logic [23:0] widen(input logic [23:0] v, input int w, input bit junk);
    return junk ? (v | 24'($urandom << w)) : v;
  endfunction

  task automatic cfg_write(input reg_idx_t ri, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= val;
    @(posedge clk);
    case (ri)
      REG_ENABLE:        cfg_shadow.enable        = val[0];
      REG_PHASE_STEP:    cfg_shadow.phase_step    = val[23:0];
      REG_DEPTH_DELAY:   cfg_shadow.depth_delay   = val[15:0];
      REG_BASE_DELAY:    cfg_shadow.base_delay    = val[15:0];
      REG_LOWPASS_COEF:  cfg_shadow.lowpass_coef  = val[15:0];
      REG_HIGH_DRY_GAIN: cfg_shadow.high_dry_gain = val[14:0];
      REG_HIGH_WET_GAIN: cfg_shadow.high_wet_gain = val[14:0];
      REG_FINAL_MIX:     cfg_shadow.final_mix     = val[15:0];
      default: ;
    endcase
  endtask

  // Writes all eight registers back to back, then drops cfg_we.
  task automatic apply_cfg(input cfg_t c, input bit junk);
    cfg_write(REG_ENABLE,        widen(24'(c.enable), 1, junk));
    cfg_write(REG_PHASE_STEP,    24'(c.phase_step));
    cfg_write(REG_DEPTH_DELAY,   widen(24'(c.depth_delay), 16, junk));
    cfg_write(REG_BASE_DELAY,    widen(24'(c.base_delay), 16, junk));
    cfg_write(REG_LOWPASS_COEF,  widen(24'(c.lowpass_coef), 16, junk));
    cfg_write(REG_HIGH_DRY_GAIN, widen(24'(c.high_dry_gain), 15, junk));
    cfg_write(REG_HIGH_WET_GAIN, widen(24'(c.high_wet_gain), 15, junk));
    cfg_write(REG_FINAL_MIX,     widen(24'(c.final_mix), 16, junk));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offer one word, with random idle cycles first; valid holds until accepted.
  task automatic send_word(input pair_t w, input bit typed, input pair_t typed_res);
    pair_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= w.left;
    right_in <= w.right;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = chorus_pair(w);
    expected_pairs.push_back(typed ? typed_res : res);
    words_in++;
  endtask

  // Stop offering, then wait until every expected word has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the driver asks for one.
  int unsigned hold_seen = 0;
  int          hold_left = 0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output checker: every accepted word against the oldest expectation.
  always @(posedge clk) begin : out_check
    pair_t want;
    if (!rst) begin
      if (in_valid && !in_ready)   in_wait_cycles++;
      if (out_valid && !out_ready) out_wait_cycles++;
      if (out_valid && out_ready) begin
        if (expected_pairs.size() == 0) begin
          $error("unexpected output word: left_out %0d, right_out %0d", left_out, right_out);
          fails++;
        end else begin
          want = expected_pairs.pop_front();
          if (left_out !== want.left) begin
            $error("left_out mismatch: expected %0d, actual %0d", $signed(want.left), left_out);
            fails++;
          end
          if (right_out !== want.right) begin
            $error("right_out mismatch: expected %0d, actual %0d",
                   $signed(want.right), right_out);
            fails++;
          end
          words_out++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random segments, drain, verdict.
  initial begin
    int cur_setting;
    int seg, n;

    cfg_shadow = CFG_RESET;
    fill_sine_quarter();
    for (int ch = 0; ch < 2; ch++) begin
      lp_state[ch]  = 0;
      prev_high[ch] = 0;
      for (int i = 0; i < DELAY_DEPTH; i++) dly_line[ch][i] = 0;
    end
    wr_pos    = 0;
    lfo_phase = '0;

    // Directed settings: reset values (bypass), effect on but fully dry,
    // near-max knobs (zero base delay) with the mix clamped, zero delay with
    // full wet gain and mix but other knobs zero, and one written with junk in the upper data bits.
    dir_cfgs[0] = CFG_RESET;
    dir_cfgs[1] = CFG_RESET;
    dir_cfgs[1].enable    = 1'b1;
    dir_cfgs[1].final_mix = 16'd0;
    dir_cfgs[2] = '{enable: 1'b1, phase_step: 24'hFFFFFF, depth_delay: 16'hFFFF,
                    base_delay: 16'h0000, lowpass_coef: 16'hFFFF, high_dry_gain: 15'h7FFF,
                    high_wet_gain: 15'h7FFF, final_mix: 16'hFFFF};
    dir_cfgs[3] = '{enable: 1'b1, phase_step: 24'h000000, depth_delay: 16'h0000,
                    base_delay: 16'h0000, lowpass_coef: 16'h0000, high_dry_gain: 15'h0000,
                    high_wet_gain: 15'h7FFF, final_mix: 16'd32768};
    dir_cfgs[4] = '{enable: 1'b1, phase_step: 24'h800000, depth_delay: 16'hFFFF,
                    base_delay: 16'hFFFF, lowpass_coef: 16'h8000, high_dry_gain: 15'd16384,
                    high_wet_gain: 15'd16384, final_mix: 16'd32769};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Config goes in only once the block has delivered everything.
    cur_setting = -1;
    for (int i = 0; i < DIR_ROWS_N; i++) begin
      if (int'(DIR_ROWS[i].setting) != cur_setting) begin
        wait_drain();
        cur_setting = int'(DIR_ROWS[i].setting);
        apply_cfg(dir_cfgs[cur_setting], cur_setting == 4);
      end
      send_word('{DIR_ROWS[i].left, DIR_ROWS[i].right}, DIR_ROWS[i].typed,
                '{DIR_ROWS[i].exp_left, DIR_ROWS[i].exp_right});
    end

    // Random segments; idle pattern rotates: none, sender, receiver, both.
    for (seg = 0; seg < RAND_SEGS; seg++) begin
      wait_drain();
      case (seg % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      apply_cfg(random_cfg(seg != 5), $urandom_range(1) == 1);
      for (n = 0; n < SEG_WORDS; n++) begin
        // Long receiver hold-off while words keep coming: block fills, input stalls.
        if (seg % 4 == 0 && n == 10) hold_reqs <= hold_reqs + 1;
        // Sender pauses mid-stream until the block is empty.
        if (seg % 4 == 1 && n == SEG_WORDS / 2) wait_drain();
        send_word(rand_pair(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (DRAIN_SLACK) @(posedge clk);

    $display("Sent %0d words, checked %0d, over %0d register settings.",
             words_in, words_out, settings_used);
    $display("Input back-pressure cycles: %0d, output stall cycles: %0d.",
             in_wait_cycles, out_wait_cycles);
    if (fails == 0 && expected_pairs.size() == 0) begin
      $display("stereo_band_split_chorus_core test passed");
    end else begin
      $display("stereo_band_split_chorus_core test failed");
    end
    $finish;
  end

  // Watchdog, sized far past the slowest legal run including the reset sweep.
  initial begin
    #(longint'(TIMEOUT_CYCLES) * 2 * CLK_HALF);
    $display("stereo_band_split_chorus_core test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sbsc_pkg.sv
rtl/sbsc_ram.sv
rtl/sbsc_lane.sv
rtl/stereo_band_split_chorus_core.sv
sim/stereo_band_split_chorus_core_tb.sv
